/* rtl/core/xlf_pkg.sv */
package xlf_pkg;

   localparam int DATA_W = 32;
   localparam int RAW_W  = 31;
   localparam int FRAC_W = 16;

   localparam logic [DATA_W-1:0] LCG_MUL    = 32'h41C6_4E6D;
   localparam logic [DATA_W-1:0] LCG_INC    = 32'h0000_3039;
   localparam logic [DATA_W-1:0] RESET_SEED = 32'h0000_029A;

   // queue between the front and back halves; keep it a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] range_low;
      logic signed [DATA_W-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic [RAW_W-1:0]         raw_value;
      logic [FRAC_W-1:0]        unit_fraction;
      logic signed [DATA_W-1:0] ranged_value;
      logic                     range_error;
   } rsp_type;

   // one draw handed from the front to the back
   typedef struct packed {
      logic [RAW_W-1:0]  raw;
      logic [DATA_W-1:0] low;
      logic [DATA_W-1:0] mag;
      logic              err;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } pop_type;

endpackage

/* rtl/core/xlf_front.sv */
module xlf_front #(
   parameter int TABLE_DEPTH = 249,
   parameter int LAG_OFFSET  = 103
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic signed [31:0]       csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  xlf_pkg::req_type         req_data,
   input  logic                     q_full,
   output xlf_pkg::push_type        q_push
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] LAG_START = IDX_W'(LAG_OFFSET % TABLE_DEPTH);

   localparam logic [1:0] FS_FILL_A = 2'd0;
   localparam logic [1:0] FS_FILL_B = 2'd1;
   localparam logic [1:0] FS_IDLE   = 2'd2;
   localparam logic [1:0] FS_READ   = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              lag_ff, lag_in;
   logic [IDX_W-1:0]              fill_cnt_ff, fill_cnt_in;
   logic [xlf_pkg::DATA_W-1:0]    lcg_ff, lcg_in;
   logic [xlf_pkg::DATA_W-1:0]    a_ff, a_in;
   logic [xlf_pkg::DATA_W-1:0]    low_ff, low_in;
   logic [xlf_pkg::DATA_W-1:0]    diff_ff, diff_in;
   logic [xlf_pkg::RAW_W-1:0]     rd_head_ff, rd_lag_ff;

   logic [xlf_pkg::RAW_W-1:0]     mem [TABLE_DEPTH];

   logic [xlf_pkg::DATA_W-1:0]    mul_op, lcg_next;
   logic                          accept;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [xlf_pkg::RAW_W-1:0]     wr_data;
   logic [xlf_pkg::RAW_W-1:0]     raw;

   assign mul_op   = (state_ff == FS_FILL_B) ? a_ff : lcg_ff;
   assign lcg_next = mul_op * xlf_pkg::LCG_MUL + xlf_pkg::LCG_INC;

   assign req_stall = !((state_ff == FS_IDLE) && !q_full);
   assign accept    = req_valid && !req_stall;
   assign raw       = rd_head_ff ^ rd_lag_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = raw;
      if (state_ff == FS_FILL_B) begin
         wr_en   = 1'b1;
         wr_addr = fill_cnt_ff;
         wr_data = {lcg_next[30:16], a_ff[31:16]};
      end else if (state_ff == FS_READ) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      q_push.push     = (state_ff == FS_READ);
      q_push.job.raw  = raw;
      q_push.job.low  = low_ff;
      q_push.job.mag  = diff_ff[xlf_pkg::DATA_W-1] ? (~diff_ff + 1'b1) : diff_ff;
      q_push.job.err  = (diff_ff == '0);
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      lag_in      = lag_ff;
      fill_cnt_in = fill_cnt_ff;
      lcg_in      = lcg_ff;
      a_in        = a_ff;
      low_in      = low_ff;
      diff_in     = diff_ff;
      case (state_ff)
         FS_FILL_A: begin
            a_in     = lcg_next;
            state_in = FS_FILL_B;
         end
         FS_FILL_B: begin
            lcg_in = lcg_next;
            if (fill_cnt_ff == LAST_IDX) begin
               fill_cnt_in = '0;
               state_in    = FS_IDLE;
            end else begin
               fill_cnt_in = fill_cnt_ff + 1'b1;
               state_in    = FS_FILL_A;
            end
         end
         FS_IDLE: begin
            if (accept) begin
               low_in   = req_data.range_low;
               diff_in  = req_data.range_high - req_data.range_low;
               state_in = FS_READ;
            end
         end
         FS_READ: begin
            head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            lag_in   = (lag_ff == LAST_IDX) ? '0 : lag_ff + 1'b1;
            state_in = FS_IDLE;
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
      // a seed write restarts the table fill
      if (csr_we) begin
         lcg_in      = csr_wdata;
         fill_cnt_in = '0;
         head_in     = '0;
         lag_in      = LAG_START;
         state_in    = FS_FILL_A;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FS_FILL_A;
         head_ff     <= '0;
         lag_ff      <= LAG_START;
         fill_cnt_ff <= '0;
         lcg_ff      <= xlf_pkg::RESET_SEED;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         lag_ff      <= lag_in;
         fill_cnt_ff <= fill_cnt_in;
         lcg_ff      <= lcg_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      low_ff  <= low_in;
      diff_ff <= diff_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_head_ff <= mem[head_ff];
      rd_lag_ff  <= mem[lag_ff];
   end

endmodule

/* rtl/core/xlf_queue.sv */
module xlf_queue (
   input  logic              clock,
   input  logic              reset,
   input  xlf_pkg::push_type q_push,
   output logic              q_full,
   input  logic              q_pop,
   output xlf_pkg::pop_type  q_head
);

   logic [xlf_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [xlf_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [xlf_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   xlf_pkg::job_type                slot_ff [xlf_pkg::QUEUE_DEPTH];

   logic do_push, do_pop;

   assign q_full       = (count_ff == xlf_pkg::QUEUE_CNT_W'(xlf_pkg::QUEUE_DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.job   = slot_ff[rd_ptr_ff];

   assign do_push = q_push.push && !q_full;
   assign do_pop  = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.job;
      end
   end

endmodule

/* rtl/core/xlf_back.sv */
module xlf_back (
   input  logic              clock,
   input  logic              reset,
   input  xlf_pkg::pop_type  q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xlf_pkg::rsp_type  rsp_data
);

   localparam int BIT_W = $clog2(xlf_pkg::RAW_W);

   localparam logic [1:0] BS_IDLE = 2'd0;
   localparam logic [1:0] BS_DIV  = 2'd1;
   localparam logic [1:0] BS_DONE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [BIT_W-1:0]            bit_ff, bit_in;
   logic [xlf_pkg::RAW_W-1:0]   dvd_ff, dvd_in;
   logic [xlf_pkg::DATA_W-1:0]  rem_ff, rem_in;
   xlf_pkg::job_type            job_ff, job_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   xlf_pkg::rsp_type            rsp_ff, rsp_in;

   logic [xlf_pkg::DATA_W:0]    shifted;
   logic [xlf_pkg::DATA_W:0]    trial;
   logic                        out_free;
   logic [xlf_pkg::DATA_W-1:0]  ranged;

   assign shifted  = {rem_ff, dvd_ff[xlf_pkg::RAW_W-1]};
   assign trial    = shifted - {1'b0, job_ff.mag};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ranged   = job_ff.err ? job_ff.low : job_ff.low + rem_ff;
   assign q_pop    = (state_ff == BS_IDLE) && q_head.valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      job_in       = job_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         BS_IDLE: begin
            if (q_head.valid) begin
               job_in   = q_head.job;
               dvd_in   = q_head.job.raw;
               rem_in   = '0;
               bit_in   = BIT_W'(xlf_pkg::RAW_W - 1);
               state_in = BS_DIV;
            end
         end
         BS_DIV: begin
            // restoring remainder step: bring down one dividend bit
            if (!trial[xlf_pkg::DATA_W]) begin
               rem_in = trial[xlf_pkg::DATA_W-1:0];
            end else begin
               rem_in = shifted[xlf_pkg::DATA_W-1:0];
            end
            dvd_in = {dvd_ff[xlf_pkg::RAW_W-2:0], 1'b0};
            if (bit_ff == '0) begin
               state_in = BS_DONE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         BS_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_in.raw_value     = job_ff.raw;
               rsp_in.unit_fraction = job_ff.raw[xlf_pkg::FRAC_W-1:0];
               rsp_in.ranged_value  = $signed(ranged);
               rsp_in.range_error   = job_ff.err;
               rsp_valid_in         = 1'b1;
               state_in             = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

/* rtl/core/xor_lagged_fibonacci_rng.sv */
// XOR lagged-Fibonacci random number generator.
// Request channel (req_valid / req_stall / req_data) carries a range
// [range_low, range_high); each accepted item draws one table word pair and
// produces exactly one item on the response channel (rsp_valid / rsp_stall /
// rsp_data): the raw 31-bit XOR, its low 16 bits as a 0.16 fraction, the
// value range_low + raw mod |range_high - range_low|, and an error flag
// when the range is empty (ranged value is then range_low).
// csr_we / csr_wdata load a new seed and refill the table.
// Reset and every seed write run a table fill, one LCG step per cycle on a
// shared multiplier; req_stall stays high during the fill.
// The front half reads the table word pair, then writes the XOR back and
// pushes the item, before it takes the next request.
// The back half computes the remainder with a bit-serial restoring unit,
// one bit per cycle; it finishes one item before it pops the next from the
// queue, which sets the sustained rate.
// A two-entry queue sits between the halves and the response is held in
// an output register, so a stalled receiver does not stop new requests
// until the queue is full.
module xor_lagged_fibonacci_rng #(
   parameter int TABLE_DEPTH = 249,
   parameter int LAG_OFFSET  = 103
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic signed [31:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  xlf_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output xlf_pkg::rsp_type   rsp_data
);

   xlf_pkg::push_type q_push;
   xlf_pkg::pop_type  q_head;
   logic              q_full;
   logic              q_pop;

   xlf_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LAG_OFFSET  (LAG_OFFSET)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   xlf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   xlf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/xlf_draw_checker.sv */
module xlf_draw_checker #(
   parameter int TABLE_DEPTH = 249,
   parameter int LAG_OFFSET  = 103
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   input  logic             req_valid,
   input  logic             req_stall,
   input  xlf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  xlf_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);

   localparam int MAX_PRINTED = 20;

   logic [30:0]      word_table [TABLE_DEPTH];
   int unsigned      head_idx;
   int unsigned      lag_idx;
   xlf_pkg::rsp_type draw_q [$];
   int               draws_checked;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      draws_checked = 0;
   end

   // Two LCG steps per word: low half from the first, high bits from the second.
   task automatic reseed(input logic [31:0] seed);
      logic [31:0] s;
      logic [31:0] a;
      s = seed;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         a = s * xlf_pkg::LCG_MUL + xlf_pkg::LCG_INC;
         s = a * xlf_pkg::LCG_MUL + xlf_pkg::LCG_INC;
         word_table[k] = {s[30:16], a[31:16]};
      end
      head_idx = 0;
      lag_idx  = LAG_OFFSET % TABLE_DEPTH;
   endtask

   task automatic predict_draw(input xlf_pkg::req_type r, output xlf_pkg::rsp_type e);
      logic [30:0] raw;
      logic [31:0] lo;
      logic [31:0] diff;
      logic [31:0] mag;
      raw = word_table[head_idx] ^ word_table[lag_idx];
      word_table[head_idx] = raw;
      head_idx = (head_idx == TABLE_DEPTH - 1) ? 0 : head_idx + 1;
      lag_idx  = (lag_idx == TABLE_DEPTH - 1) ? 0 : lag_idx + 1;
      lo   = r.range_low;
      diff = r.range_high - r.range_low;
      e.raw_value     = raw;
      e.unit_fraction = raw[15:0];
      if (diff == 32'd0) begin
         // empty range: return the low bound and flag it
         e.ranged_value = lo;
         e.range_error  = 1'b1;
      end else begin
         mag = diff[31] ? 32'd0 - diff : diff;
         e.ranged_value = lo + ({1'b0, raw} % mag);
         e.range_error  = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("ERROR: draw %0d %s: got %h, expected %h",
                  draws_checked, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      xlf_pkg::rsp_type predicted;
      xlf_pkg::rsp_type want;
      if (reset) begin
         reseed(xlf_pkg::RESET_SEED);
         draw_q.delete();
      end else begin
         if (csr_we)
            reseed(csr_wdata);
         if (req_valid && !req_stall) begin
            predict_draw(req_data, predicted);
            draw_q.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (draw_q.size() == 0) begin
               report_mismatch("result with no draw pending",
                               32'(rsp_data.raw_value), '0);
            end else begin
               want = draw_q.pop_front();
               if (rsp_data.raw_value !== want.raw_value)
                  report_mismatch("raw_value", 32'(rsp_data.raw_value),
                                  32'(want.raw_value));
               if (rsp_data.unit_fraction !== want.unit_fraction)
                  report_mismatch("unit_fraction", 32'(rsp_data.unit_fraction),
                                  32'(want.unit_fraction));
               if (rsp_data.ranged_value !== want.ranged_value)
                  report_mismatch("ranged_value", rsp_data.ranged_value,
                                  want.ranged_value);
               if (rsp_data.range_error !== want.range_error)
                  report_mismatch("range_error", 32'(rsp_data.range_error),
                                  32'(want.range_error));
               draws_checked++;
            end
         end
      end
      pending_count <= draw_q.size();
   end

endmodule

/* sim/tb_top.sv */
module tb_top;

   localparam int PERIOD        = 12;
   localparam int LIMIT_CYCLES  = 600_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 120;
   localparam int TABLE_DEPTH   = 249;
   localparam int LAG_OFFSET    = 103;
   localparam int NUM_SEEDS     = 6;

   localparam logic [31:0] MOST_NEG = 32'h8000_0000;
   localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [31:0]      csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   xlf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   xlf_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending_count;

   xlf_pkg::req_type corner_q [$];
   int               sent = 0;

   always begin
      #(PERIOD / 2) clock = 1'b1;
      #(PERIOD / 2) clock = 1'b0;
   end

   xor_lagged_fibonacci_rng #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LAG_OFFSET  (LAG_OFFSET)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   xlf_draw_checker #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LAG_OFFSET  (LAG_OFFSET)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   function automatic logic [31:0] corner_value();
      case ($urandom_range(0, 4))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return 32'd0;
         3: return 32'hFFFF_FFFF;
         default: return 32'd1;
      endcase
   endfunction

   function automatic xlf_pkg::req_type random_range();
      xlf_pkg::req_type r;
      logic [31:0]      lo;
      logic [31:0]      span;
      lo = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: span = $urandom;
         4, 5: span = $urandom_range(1, 300);
         6: span = 32'd0;
         7: span = 32'd1 << $urandom_range(0, 31);
         8: span = MOST_NEG;
         default: begin
            lo   = corner_value();
            span = corner_value() - lo;
         end
      endcase
      if ($urandom_range(0, 1))
         span = 32'd0 - span;
      r.range_low  = lo;
      r.range_high = lo + span;
      return r;
   endfunction

   // mostly back to back or short gaps, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   task automatic push_corner(input logic [31:0] lo, input logic [31:0] hi);
      xlf_pkg::req_type r;
      r.range_low  = lo;
      r.range_high = hi;
      corner_q.push_back(r);
   endtask

   // hold the item until the block takes it
   task automatic send_item(input xlf_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_stall);
      sent++;
   endtask

   task automatic pause_sender();
      int n;
      n = idle_cycles();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic run_draws(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(random_range());
         // every third stretch of 32 items goes back to back
         if ((i / 32) % 3 != 1)
            pause_sender();
      end
   endtask

   // wait until every expected result is in and the pipeline is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_seed(input logic [31:0] seed);
      csr_we    <= 1'b1;
      csr_wdata <= seed;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : receiver
      int  taken;
      int  span;
      bit  held_long;
      bit  level;
      int  r;
      taken     = 0;
      held_long = 1'b0;
      forever begin
         if (!held_long && taken >= HOLD_AFTER) begin
            // long hold-off so the block backs up into its input
            held_long = 1'b1;
            level     = 1'b1;
            span      = LONG_HOLD;
         end else begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
               level = 1'b0;
               span  = $urandom_range(20, 80);
            end else if (r < 7) begin
               level = 1'b0;
               span  = $urandom_range(1, 4);
            end else if (r < 9) begin
               level = 1'b1;
               span  = $urandom_range(1, 3);
            end else begin
               level = 1'b1;
               span  = $urandom_range(10, 40);
            end
         end
         rsp_stall <= level;
         repeat (span) begin
            @(posedge clock);
            if (rsp_valid && !rsp_stall)
               taken++;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] seeds [NUM_SEEDS];
      seeds[0] = 32'h0000_0000;
      seeds[1] = MOST_POS;
      seeds[2] = MOST_NEG;
      seeds[3] = 32'hFFFF_FFFF;
      seeds[4] = 32'h0000_0001;
      seeds[5] = $urandom;

      push_corner(32'd0, 32'd1);
      push_corner(32'd0, 32'd0);
      push_corner(MOST_NEG, MOST_NEG);
      push_corner(MOST_POS, MOST_POS);
      push_corner(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_corner(32'd0, MOST_NEG);
      push_corner(MOST_NEG, 32'd0);
      push_corner(MOST_POS, MOST_NEG);
      push_corner(MOST_NEG, MOST_POS);
      push_corner(32'hFFFF_FFFF, MOST_POS);
      push_corner(32'd10, -32'sd10);
      push_corner(-32'sd100, 32'd100);
      push_corner(32'd0, MOST_POS);
      push_corner(32'd1, MOST_NEG);
      push_corner(MOST_POS, 32'd0);
      push_corner(-32'sd5, 32'd3);
      push_corner(32'd0, 32'd65536);
      push_corner(32'd123456, 32'd123457);
      push_corner(32'hFFFF_FFFF, 32'd0);
      push_corner(32'd0, 32'd2);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset seed first: corner ranges, then random ones
      foreach (corner_q[i]) begin
         send_item(corner_q[i]);
         pause_sender();
      end
      run_draws(180);
      settle();

      for (int p = 0; p < NUM_SEEDS; p++) begin
         load_seed(seeds[p]);
         run_draws(145);
         settle();
      end

      $display("Summary: %0d draws over %0d seeds (reset seed, zero, both sign extremes,",
               sent, NUM_SEEDS + 1);
      $display("  all ones, one, random); empty, wrapped and half-range spans included");
      if (pending_count != 0)
         $display("ERROR: %0d expected results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * PERIOD);
      $display("ERROR: timeout after %0d cycles", LIMIT_CYCLES);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/xlf_pkg.sv
rtl/core/xlf_front.sv
rtl/core/xlf_queue.sv
rtl/core/xlf_back.sv
rtl/core/xor_lagged_fibonacci_rng.sv
sim/xlf_draw_checker.sv
sim/tb_top.sv
